[hdl/ssg_pkg.sv]
// Shared types and constants for the stepper axis step generator.
package ssg_pkg;

  localparam int unsigned COUNT_WIDTH_DEF    = 16;
  localparam int unsigned POSITION_WIDTH_DEF = 12;
  localparam int unsigned CFG_WIDTH          = 12;
  localparam int unsigned POS_PORT_WIDTH     = 12;
  localparam int unsigned FRAC_BITS          = 8;

  localparam logic [CFG_WIDTH-1:0] STEPS_PER_SQUARE_RST = 12'd315;
  localparam logic [CFG_WIDTH-1:0] HOME_POSITION_RST    = 12'd172;

  localparam logic [2:0] ADDR_STEPS_PER_SQUARE = 3'd0;
  localparam logic [2:0] ADDR_HOME_POSITION    = 3'd4;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_MOVE  = 2'd1,
    OP_TIMED = 2'd2,
    OP_SEEK  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    MODE_IDLE     = 4'b0001,
    MODE_POSITION = 4'b0010,
    MODE_TIMED    = 4'b0100,
    MODE_SEEK     = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [POS_PORT_WIDTH-1:0] current_position;
    logic                      done_res;
    logic                      busy_res;
    logic                      motor_enable;
    logic                      direction_out;
    logic                      step_out;
  } result_t;

endpackage

[hdl/stepper_axis_step_generator_top.sv]
// Step/dir pulse generator and move sequencer for one stepper axis.
//
//  channel   | dir | tdata (low bit first)                                  | tuser
//  s_axis    | in  | target_position[11:0], step_count[15:0], move_direction, | operation
//            |     | limit_switch_level, 2 pad bits                         |
//  m_axis    | out | step_out, direction_out, motor_enable, busy_res,       | -
//            |     | done_res, current_position[11:0], 7 pad bits           |
//  apb       | in  | steps_per_square @0x0, home_position @0x4              | -
//
//  One beat in, one beat out; a beat is accepted every cycle unless a stalled result blocks input.
//  The axis state and the result register update at the accept edge; the result is valid the cycle after.
//  The step count multiply is a single POSITION_WIDTH x 12 product in the accept path.
//  A stalled result holds in the output register; input is taken whenever it drains that cycle.
//  Reset clears the axis state and loads the register defaults.
module stepper_axis_step_generator_top #(
  parameter int unsigned COUNT_WIDTH    = ssg_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned POSITION_WIDTH = ssg_pkg::POSITION_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // target_position, step_count, move_direction, limit_switch_level
  input  logic [1:0]  s_axis_tuser,  // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // step_out, direction_out, motor_enable, busy_res,
                                     // done_res, current_position
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ssg_pkg::*;

  localparam int unsigned PROD_WIDTH  = POSITION_WIDTH + CFG_WIDTH;
  localparam int unsigned STEPS_WIDTH = PROD_WIDTH - FRAC_BITS;

  logic [CFG_WIDTH-1:0]      steps_per_square;
  logic [CFG_WIDTH-1:0]      home_position;

  logic                      step_level, step_level_next;
  logic                      direction_level, direction_level_next;
  logic                      enabled, enabled_next;
  mode_t                     move_mode, move_mode_next;
  logic [COUNT_WIDTH-1:0]    remaining_steps, remaining_steps_next;
  logic [POSITION_WIDTH-1:0] axis_position, axis_position_next;
  logic                      done_next;

  logic                      out_valid;
  result_t                   out_res;

  logic                      in_accept;
  op_t                       op;
  logic [POSITION_WIDTH-1:0] target;
  logic [15:0]               count_in;
  logic                      dir_in;
  logic                      sw_in;
  logic [POSITION_WIDTH-1:0] diff;
  logic [PROD_WIDTH-1:0]     product;
  logic [STEPS_WIDTH-1:0]    steps_raw;
  logic [COUNT_WIDTH-1:0]    move_steps;
  logic [COUNT_WIDTH-1:0]    timed_steps;
  logic [COUNT_WIDTH-1:0]    remaining_dec;

  // Configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_per_square <= STEPS_PER_SQUARE_RST;
      home_position    <= HOME_POSITION_RST;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == ADDR_HOME_POSITION[2]) begin
        home_position <= pwdata[CFG_WIDTH-1:0];
      end else begin
        steps_per_square <= pwdata[CFG_WIDTH-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == ADDR_HOME_POSITION[2]) begin
      prdata = {{(32-CFG_WIDTH){1'b0}}, home_position};
    end else begin
      prdata = {{(32-CFG_WIDTH){1'b0}}, steps_per_square};
    end
  end

  // Input decode
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign op       = op_t'(s_axis_tuser);
  assign target   = POSITION_WIDTH'(s_axis_tdata[11:0]);
  assign count_in = s_axis_tdata[27:12];
  assign dir_in   = s_axis_tdata[28];
  assign sw_in    = s_axis_tdata[29];

  // Step count for a position move
  assign diff      = (target < axis_position) ? (axis_position - target)
                                              : (target - axis_position);
  assign product   = PROD_WIDTH'(diff) * PROD_WIDTH'(steps_per_square);
  assign steps_raw = product[PROD_WIDTH-1:FRAC_BITS];

  always_comb begin
    if ((steps_raw >> COUNT_WIDTH) != '0) begin
      move_steps = '1;
    end else begin
      move_steps = COUNT_WIDTH'(steps_raw);
    end
    if ((count_in >> COUNT_WIDTH) != '0) begin
      timed_steps = '1;
    end else begin
      timed_steps = COUNT_WIDTH'(count_in);
    end
  end

  assign remaining_dec = (remaining_steps != '0) ? remaining_steps - 1'b1 : remaining_steps;

  // Sequencer
  always_comb begin
    step_level_next      = step_level;
    direction_level_next = direction_level;
    enabled_next         = enabled;
    move_mode_next       = move_mode;
    remaining_steps_next = remaining_steps;
    axis_position_next   = axis_position;
    done_next            = 1'b0;

    if (op == OP_TICK) begin
      if (move_mode != MODE_IDLE) begin
        step_level_next = !step_level;
        if (step_level) begin
          if (move_mode == MODE_SEEK) begin
            if (!sw_in) begin
              axis_position_next   = POSITION_WIDTH'(home_position);
              move_mode_next       = MODE_IDLE;
              enabled_next         = 1'b0;
              remaining_steps_next = '0;
              done_next            = 1'b1;
            end
          end else begin
            remaining_steps_next = remaining_dec;
            if (remaining_dec == '0) begin
              move_mode_next = MODE_IDLE;
              enabled_next   = 1'b0;
              done_next      = 1'b1;
            end
          end
        end
      end
    end else if (move_mode == MODE_IDLE) begin
      case (op)
        OP_MOVE: begin
          if (target == axis_position) begin
            done_next = 1'b1;
          end else begin
            direction_level_next = (target > axis_position);
            axis_position_next   = target;
            if (move_steps == '0) begin
              done_next = 1'b1;
            end else begin
              enabled_next         = 1'b1;
              remaining_steps_next = move_steps;
              move_mode_next       = MODE_POSITION;
            end
          end
        end
        OP_TIMED: begin
          if (count_in == '0) begin
            done_next = 1'b1;
          end else begin
            direction_level_next = dir_in;
            enabled_next         = 1'b1;
            remaining_steps_next = timed_steps;
            move_mode_next       = MODE_TIMED;
          end
        end
        OP_SEEK: begin
          direction_level_next = dir_in;
          enabled_next         = 1'b1;
          move_mode_next       = MODE_SEEK;
        end
        default: begin
          done_next = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_level      <= 1'b0;
      direction_level <= 1'b0;
      enabled         <= 1'b0;
      move_mode       <= MODE_IDLE;
      remaining_steps <= '0;
      axis_position   <= '0;
    end else if (in_accept) begin
      step_level      <= step_level_next;
      direction_level <= direction_level_next;
      enabled         <= enabled_next;
      move_mode       <= move_mode_next;
      remaining_steps <= remaining_steps_next;
      axis_position   <= axis_position_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_res.step_out         <= step_level_next;
      out_res.direction_out    <= direction_level_next;
      out_res.motor_enable     <= enabled_next;
      out_res.busy_res         <= (move_mode_next != MODE_IDLE);
      out_res.done_res         <= done_next;
      out_res.current_position <= POS_PORT_WIDTH'(axis_position_next);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'b0, out_res};

  // Checks
  a_busy_enabled: assert property (@(posedge clk) disable iff (rst)
    (move_mode != MODE_IDLE) |-> enabled)
    else $error("axis busy with driver disabled");

  a_idle_no_count: assert property (@(posedge clk) disable iff (rst)
    (move_mode == MODE_IDLE) |-> (remaining_steps == '0))
    else $error("idle axis holds a step count");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.done_res) |-> !out_res.busy_res)
    else $error("completed move still reported busy");

  a_step_only_on_beat: assert property (@(posedge clk) disable iff (rst)
    !in_accept |=> $stable(step_level))
    else $error("step level moved without an input beat");

endmodule
